FILE: design/adsr_pkg.sv
// shared types and constants of the adsr envelope generator
package adsr_pkg;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ATTACK_STEP    = 3'd0,
    REG_DECAY_FACTOR   = 3'd1,
    REG_SUSTAIN_LEVEL  = 3'd2,
    REG_RELEASE_FACTOR = 3'd3,
    REG_HOLD_SAMPLES   = 3'd4
  } cfg_reg_t;

  localparam int ATTACK_STEP_RESET    = 655;
  localparam int DECAY_FACTOR_RESET   = 65500;
  localparam int SUSTAIN_LEVEL_RESET  = 45875;
  localparam int RELEASE_FACTOR_RESET = 65500;
  localparam int HOLD_SAMPLES_RESET   = 0;

endpackage

FILE: design/adsr_serial_mult.sv
// bit-serial shift-add multiplier, signed multiplicand times unsigned multiplier
module adsr_serial_mult import adsr_pkg::*; #(
  parameter int WA = 18,
  parameter int WB = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WA-1:0]        a,
  input  logic [WB-1:0]        b,
  output logic                 done,
  output logic [WA+WB-1:0]     prod
);

  localparam int CW = $clog2(WB + 1);

  logic [WA-1:0] a_reg;
  logic [WA:0]   hi;
  logic [WB-1:0] lo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [WA:0]   sum;
  logic [WA:0]   addend;
  logic [WA+WB:0] full;

  assign addend = lo[0] ? {a_reg[WA-1], a_reg} : '0;
  assign sum    = hi + addend;
  assign full   = {hi, lo};
  assign prod   = full[WA+WB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        a_reg <= a;
        hi    <= '0;
        lo    <= b;
        cnt   <= CW'(WB);
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= {sum[WA], sum[WA:1]};
        lo  <= {sum[0], lo[WB-1:1]};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: design/adsr_envelope_generator.sv
// adsr envelope generator top level: config registers, phase sequencer, output register
// each product is computed on the one shared bit-serial multiplier
// up to three products per sample: decay, release and the sample scaling
// one sample in flight; the next beat is taken while the result waits in the output register
// synchronous reset clears phase state, amplitude and counters and loads register defaults
module adsr_envelope_generator import adsr_pkg::*; #(
  parameter int AMP_FRAC_BITS = 16,
  parameter int SAMPLE_BITS   = 16,
  parameter int HOLD_BITS     = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_in
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // gate
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // sample_out, level
  output logic [((SAMPLE_BITS+AMP_FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((AMP_FRAC_BITS+1 > HOLD_BITS) ? AMP_FRAC_BITS+1 : HOLD_BITS)-1:0] cfg_data
);

  localparam int F        = AMP_FRAC_BITS;
  localparam int AMP_BITS = F + 1;
  localparam int WA       = ((SAMPLE_BITS > AMP_BITS) ? SAMPLE_BITS : AMP_BITS) + 1;
  localparam int WB       = AMP_BITS;
  localparam int OUT_W    = ((SAMPLE_BITS + AMP_BITS + 7) / 8) * 8;
  localparam logic [AMP_BITS-1:0] AMP_ONE = AMP_BITS'(1) << F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ATTACK,
    ST_DECAY_MUL,
    ST_HOLD,
    ST_REL_MUL,
    ST_SHAPE,
    ST_SHAPE_MUL,
    ST_DONE
  } state_t;

  state_t state;

  logic [F-1:0]           attack_step;
  logic [F-1:0]           decay_factor;
  logic [AMP_BITS-1:0]    sustain_level;
  logic [F-1:0]           release_factor;
  logic [HOLD_BITS-1:0]   hold_samples;

  logic                   in_attack;
  logic                   in_decay;
  logic                   in_hold;
  logic                   in_release;
  logic [AMP_BITS-1:0]    amplitude;
  logic [HOLD_BITS-1:0]   hold_count;
  logic [SAMPLE_BITS-1:0] last_output;

  logic [SAMPLE_BITS-1:0] smp;
  logic                   gate_r;
  logic                   take;
  logic                   mul_start;

  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic [AMP_BITS-1:0]    out_level;

  logic [WA-1:0]          mult_a;
  logic [WB-1:0]          mult_b;
  logic                   mult_done;
  logic [WA+WB-1:0]       mult_prod;
  logic [AMP_BITS-1:0]    scaled;

  logic                   start_note;
  logic                   attacking;
  logic [AMP_BITS:0]      att_sum;
  logic                   hold_inc;
  logic [HOLD_BITS-1:0]   hc_new;
  logic                   hold_done;
  logic                   rel_set;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_level, out_sample});

  assign start_note = gate_r && !in_attack && !in_hold && !in_decay;
  assign attacking  = in_attack || start_note;
  assign att_sum    = {1'b0, amplitude} + (AMP_BITS+1)'(attack_step);
  assign hold_inc   = in_hold && (hold_count < hold_samples);
  assign hc_new     = hold_inc ? hold_count + HOLD_BITS'(1) : hold_count;
  assign hold_done  = (hc_new >= hold_samples);
  assign rel_set    = hold_done && !gate_r;
  assign scaled     = mult_prod[F +: AMP_BITS];

  always_comb begin
    case (state)
      ST_DECAY_MUL: begin
        mult_a = WA'(amplitude);
        mult_b = WB'(decay_factor);
      end
      ST_REL_MUL: begin
        mult_a = WA'(amplitude);
        mult_b = WB'(release_factor);
      end
      ST_SHAPE_MUL: begin
        mult_a = WA'($signed(smp));
        mult_b = amplitude;
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  adsr_serial_mult #(
    .WA (WA),
    .WB (WB)
  ) u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mult_a),
    .b     (mult_b),
    .done  (mult_done),
    .prod  (mult_prod)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step    <= F'(ATTACK_STEP_RESET);
      decay_factor   <= F'(DECAY_FACTOR_RESET);
      sustain_level  <= AMP_BITS'(SUSTAIN_LEVEL_RESET);
      release_factor <= F'(RELEASE_FACTOR_RESET);
      hold_samples   <= HOLD_BITS'(HOLD_SAMPLES_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTACK_STEP:    attack_step    <= cfg_data[F-1:0];
        REG_DECAY_FACTOR:   decay_factor   <= cfg_data[F-1:0];
        REG_SUSTAIN_LEVEL:  sustain_level  <= cfg_data[AMP_BITS-1:0];
        REG_RELEASE_FACTOR: release_factor <= cfg_data[F-1:0];
        REG_HOLD_SAMPLES:   hold_samples   <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      in_attack   <= 1'b0;
      in_decay    <= 1'b0;
      in_hold     <= 1'b0;
      in_release  <= 1'b0;
      amplitude   <= '0;
      hold_count  <= '0;
      last_output <= '0;
      take        <= 1'b0;
      mul_start   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          mul_start <= 1'b0;
          if (s_axis_tvalid) begin
            smp    <= s_axis_tdata[SAMPLE_BITS-1:0];
            gate_r <= s_axis_tuser;
            state  <= ST_ATTACK;
          end
        end
        ST_ATTACK: begin
          take <= attacking;
          if (start_note) begin
            hold_count <= '0;
          end
          if (attacking) begin
            in_release <= 1'b0;
            if (att_sum >= {1'b0, AMP_ONE}) begin
              amplitude <= AMP_ONE;
              in_attack <= 1'b0;
              in_decay  <= 1'b1;
              mul_start <= 1'b1;
              state     <= ST_DECAY_MUL;
            end else begin
              amplitude <= att_sum[AMP_BITS-1:0];
              in_attack <= 1'b1;
              state     <= in_decay ? ST_DECAY_MUL : ST_HOLD;
              mul_start <= in_decay;
            end
          end else begin
            state     <= in_decay ? ST_DECAY_MUL : ST_HOLD;
            mul_start <= in_decay;
          end
        end
        ST_DECAY_MUL: begin
          mul_start <= 1'b0;
          if (mult_done) begin
            amplitude <= scaled;
            take      <= 1'b1;
            if (scaled <= sustain_level) begin
              in_decay <= 1'b0;
              in_hold  <= 1'b1;
            end
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          hold_count <= hc_new;
          if (hold_inc || (hold_done && gate_r)) begin
            take <= 1'b1;
          end
          if (rel_set) begin
            in_hold    <= 1'b0;
            in_release <= 1'b1;
          end
          if ((in_release || rel_set) && (amplitude != '0)) begin
            mul_start <= 1'b1;
            state     <= ST_REL_MUL;
          end else begin
            mul_start <= 1'b0;
            state     <= ST_SHAPE;
          end
        end
        ST_REL_MUL: begin
          mul_start <= 1'b0;
          if (mult_done) begin
            amplitude <= scaled;
            take      <= 1'b1;
            state     <= ST_SHAPE;
          end
        end
        ST_SHAPE: begin
          if (take) begin
            mul_start <= 1'b1;
            state     <= ST_SHAPE_MUL;
          end else begin
            mul_start <= 1'b0;
            state     <= ST_DONE;
          end
        end
        ST_SHAPE_MUL: begin
          mul_start <= 1'b0;
          if (mult_done) begin
            last_output <= mult_prod[F +: SAMPLE_BITS];
            state       <= ST_DONE;
          end
        end
        ST_DONE: begin
          mul_start <= 1'b0;
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_sample <= last_output;
            out_level  <= amplitude;
            state      <= ST_IDLE;
          end
        end
        default: begin
          mul_start <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  a_amp_bound: assert property (@(posedge clk) disable iff (rst)
    amplitude <= AMP_ONE)
    else $error("amplitude above one");

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({in_attack, in_decay, in_hold}))
    else $error("attack, decay and hold overlap");

  a_mult_owner: assert property (@(posedge clk) disable iff (rst)
    mult_done |-> (state == ST_DECAY_MUL || state == ST_REL_MUL || state == ST_SHAPE_MUL))
    else $error("multiplier finished outside a product state");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_ATTACK))
    else $error("accepted beat did not start the phase update");

endmodule
